### rtl/core/jxl_container_box_deframer_defines.svh
// assertion macros shared by the container deframer modules
`ifndef JXL_CONTAINER_BOX_DEFRAMER_DEFINES_SVH
`define JXL_CONTAINER_BOX_DEFRAMER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define JXLCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jxlcbd assertion failed");
// next-cycle implication, disabled during reset
`define JXLCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jxlcbd assertion failed");
`else
`define JXLCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JXLCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/jxlcbd_pkg.sv
// types, codes and tables of the container deframer
package jxlcbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 64;

    localparam int SIZE_WIDTH_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CS     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXIF   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_XML    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_JBRD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_JXL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_EXT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT_JXLP = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_CS     = 3'd5;

    // bare codestream marker
    localparam logic [BYTE_W-1:0] BARE_MARK0 = 8'hff;
    localparam logic [BYTE_W-1:0] BARE_MARK1 = 8'h0a;

    localparam logic [3:0] SIG_LEN = 4'd12;

    // box types
    localparam logic [31:0] BOX_JXLC = 32'h6a786c63;
    localparam logic [31:0] BOX_JXLP = 32'h6a786c70;
    localparam logic [31:0] BOX_EXIF = 32'h45786966;
    localparam logic [31:0] BOX_XML  = 32'h786d6c20;
    localparam logic [31:0] BOX_JBRD = 32'h6a627264;

    // up to three results caused by one input item
    typedef struct packed {
        logic                pay_valid;
        logic [KIND_W-1:0]   pay_kind;
        logic [BYTE_W-1:0]   pay_byte;
        logic                pair;
        logic                st_valid;
        logic [STATUS_W-1:0] st_code;
        logic [TOTAL_W-1:0]  total;
    } rec_t;

    // container signature bytes
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [3:0] idx);
        logic [BYTE_W-1:0] val;
        val = 8'h00;
        case (idx)
            4'd3:    val = 8'h0c;
            4'd4:    val = 8'h4a;
            4'd5:    val = 8'h58;
            4'd6:    val = 8'h4c;
            4'd7:    val = 8'h20;
            4'd8:    val = 8'h0d;
            4'd9:    val = 8'h0a;
            4'd10:   val = 8'h87;
            4'd11:   val = 8'h0a;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### rtl/core/jxlcbd_if.sv
// byte and result channel interfaces of the container deframer
interface jxlcbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [jxlcbd_pkg::BYTE_W-1:0] byte_in;
    logic                          end_of_file;

    modport source (output valid, byte_in, end_of_file, input ready);
    modport sink   (input valid, byte_in, end_of_file, output ready);
endinterface

interface jxlcbd_out_if;
    logic                            valid;
    logic                            ready;
    logic [jxlcbd_pkg::KIND_W-1:0]   kind;
    logic [jxlcbd_pkg::BYTE_W-1:0]   byte_out;
    logic [jxlcbd_pkg::STATUS_W-1:0] status;
    logic [jxlcbd_pkg::TOTAL_W-1:0]  codestream_total;
    logic                            last_of_file;

    modport source (output valid, kind, byte_out, status, codestream_total, last_of_file,
                    input ready);
    modport sink   (input valid, kind, byte_out, status, codestream_total, last_of_file,
                    output ready);
endinterface

### rtl/core/jxl_container_box_deframer.sv
// top level of the container box deframer: parser, record queue and result output
// Path: a result passes through the record queue and then the output register.
// Throughput: one file byte per cycle while the queue is not full; one byte can cause
//   up to 3 results, and a QUEUE_DEPTH-record queue absorbs such bursts.
// Reset: rst_n clears the parser to the signature phase and empties queue and output;
//   the block then returns to that state by itself after each final byte.
module jxl_container_box_deframer #(
    parameter int SIZE_WIDTH  = jxlcbd_pkg::SIZE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = jxlcbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    jxlcbd_in_if.sink     byte_ch,
    jxlcbd_out_if.source  result_ch
);

    logic             push;
    jxlcbd_pkg::rec_t push_rec;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    jxlcbd_pkg::rec_t head_rec;

    // parser and classifier
    jxlcbd_front #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // record queue
    jxlcbd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // result item output
    jxlcbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .result_ch  (result_ch)
    );

endmodule

### rtl/core/jxlcbd_front.sv
// front end: signature check, box header parse and result classification
`include "jxl_container_box_deframer_defines.svh"

module jxlcbd_front #(
    parameter int SIZE_WIDTH = jxlcbd_pkg::SIZE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    jxlcbd_in_if.sink         byte_ch,
    input  logic              q_full,
    output logic              push,
    output jxlcbd_pkg::rec_t  push_rec
);

    localparam int SW = SIZE_WIDTH;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_FF,
        PH_BARE,
        PH_HDR,
        PH_PAY,
        PH_DROP
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [3:0]                         sig_idx_reg, sig_idx_next;
    logic [4:0]                         hdr_cnt_reg, hdr_cnt_next;
    logic [SW-1:0]                      box_len_reg, box_len_next;
    logic                               box_ovf_reg, box_ovf_next;
    logic [31:0]                        box_kind_reg, box_kind_next;
    logic [SW-1:0]                      pay_left_reg, pay_left_next;
    logic                               to_end_reg, to_end_next;
    logic                               found_reg, found_next;
    logic [jxlcbd_pkg::STATUS_W-1:0]    err_reg, err_next;
    logic [jxlcbd_pkg::TOTAL_W-1:0]     cs_count_reg, cs_count_next;

    logic                               accept;
    logic [jxlcbd_pkg::BYTE_W-1:0]      b;
    logic [4:0]                         hc_inc;
    logic [SW-1:0]                      len_sh;
    logic                               ovf_sh;
    logic [SW-1:0]                      len_clamp;
    logic                               begin_pay;
    logic                               pay_small;
    logic                               pay_zero;
    logic                               hdr_reset;
    logic                               do_fail;
    logic [jxlcbd_pkg::STATUS_W-1:0]    fail_code;
    logic                               inc_one;
    logic                               set_two;
    jxlcbd_pkg::rec_t                   rec;

    assign accept        = byte_ch.valid && byte_ch.ready;
    assign byte_ch.ready = !q_full;
    assign b             = byte_ch.byte_in;

    // header length shift with sticky overflow above the size range
    assign hc_inc    = hdr_cnt_reg + 5'd1;
    assign len_sh    = {box_len_reg[SW-9:0], b};
    assign ovf_sh    = box_ovf_reg || (|box_len_reg[SW-1:SW-8]);
    assign len_clamp = ovf_sh ? {SW{1'b1}} : len_sh;

    // per-byte parse step
    always_comb
    begin
        phase_next    = phase_reg;
        sig_idx_next  = sig_idx_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        box_len_next  = box_len_reg;
        box_ovf_next  = box_ovf_reg;
        box_kind_next = box_kind_reg;
        pay_left_next = pay_left_reg;
        to_end_next   = to_end_reg;
        found_next    = found_reg;
        err_next      = err_reg;
        cs_count_next = cs_count_reg;
        begin_pay     = 1'b0;
        pay_small     = 1'b0;
        pay_zero      = 1'b0;
        hdr_reset     = 1'b0;
        do_fail       = 1'b0;
        fail_code     = jxlcbd_pkg::ST_OK;
        inc_one       = 1'b0;
        set_two       = 1'b0;
        rec           = '0;

        unique case (phase_reg)
            PH_SIG:
            begin
                if (sig_idx_reg == 4'd0 && b == jxlcbd_pkg::BARE_MARK0)
                begin
                    phase_next = PH_FF;
                end
                else if (sig_idx_reg >= jxlcbd_pkg::SIG_LEN ||
                         b != jxlcbd_pkg::sig_byte(sig_idx_reg))
                begin
                    do_fail   = 1'b1;
                    fail_code = jxlcbd_pkg::ST_NOT_JXL;
                end
                else
                begin
                    sig_idx_next = sig_idx_reg + 4'd1;
                    if (sig_idx_next == jxlcbd_pkg::SIG_LEN)
                    begin
                        hdr_reset = 1'b1;
                    end
                end
            end
            PH_FF:
            begin
                if (b == jxlcbd_pkg::BARE_MARK1)
                begin
                    rec.pay_valid = 1'b1;
                    rec.pay_kind  = jxlcbd_pkg::KIND_CS;
                    rec.pay_byte  = jxlcbd_pkg::BARE_MARK0;
                    rec.pair      = 1'b1;
                    set_two       = 1'b1;
                    found_next    = 1'b1;
                    phase_next    = PH_BARE;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = jxlcbd_pkg::ST_NOT_JXL;
                end
            end
            PH_BARE:
            begin
                rec.pay_valid = 1'b1;
                rec.pay_kind  = jxlcbd_pkg::KIND_CS;
                rec.pay_byte  = b;
                inc_one       = 1'b1;
            end
            PH_HDR:
            begin
                if (hdr_cnt_reg < 5'd4 || hdr_cnt_reg >= 5'd8)
                begin
                    box_len_next = len_sh;
                    box_ovf_next = ovf_sh;
                end
                else
                begin
                    box_kind_next = {box_kind_reg[23:0], b};
                end
                hdr_cnt_next = hc_inc;
                // compact header done: the last byte was a type byte
                if (hc_inc == 5'd8)
                begin
                    if (box_len_reg == SW'(1))
                    begin
                        box_len_next = '0;
                        box_ovf_next = 1'b0;
                    end
                    else if (box_len_reg == '0)
                    begin
                        to_end_next = 1'b1;
                        begin_pay   = 1'b1;
                    end
                    else if (box_len_reg < SW'(8))
                    begin
                        do_fail   = 1'b1;
                        fail_code = jxlcbd_pkg::ST_BAD_SIZE;
                    end
                    else
                    begin
                        pay_left_next = box_len_reg - SW'(8);
                        pay_small     = box_len_reg < SW'(12);
                        pay_zero      = box_len_reg == SW'(8);
                        begin_pay     = 1'b1;
                    end
                end
                // extended size done
                else if (hc_inc == 5'd16)
                begin
                    if (!ovf_sh && len_sh < SW'(16))
                    begin
                        do_fail   = 1'b1;
                        fail_code = jxlcbd_pkg::ST_BAD_EXT;
                    end
                    else
                    begin
                        box_len_next  = len_clamp;
                        pay_left_next = len_clamp - SW'(16);
                        pay_small     = len_clamp < SW'(20);
                        pay_zero      = len_clamp == SW'(16);
                        begin_pay     = 1'b1;
                    end
                end
            end
            PH_PAY:
            begin
                if (hdr_cnt_reg != 5'd0)
                begin
                    hdr_cnt_next = hdr_cnt_reg - 5'd1;
                end
                else if (box_kind_reg == jxlcbd_pkg::BOX_JXLC ||
                         box_kind_reg == jxlcbd_pkg::BOX_JXLP)
                begin
                    rec.pay_valid = 1'b1;
                    rec.pay_kind  = jxlcbd_pkg::KIND_CS;
                    inc_one       = 1'b1;
                end
                else if (box_kind_reg == jxlcbd_pkg::BOX_EXIF)
                begin
                    rec.pay_valid = 1'b1;
                    rec.pay_kind  = jxlcbd_pkg::KIND_EXIF;
                end
                else if (box_kind_reg == jxlcbd_pkg::BOX_XML)
                begin
                    rec.pay_valid = 1'b1;
                    rec.pay_kind  = jxlcbd_pkg::KIND_XML;
                end
                else if (box_kind_reg == jxlcbd_pkg::BOX_JBRD)
                begin
                    rec.pay_valid = 1'b1;
                    rec.pay_kind  = jxlcbd_pkg::KIND_JBRD;
                end
                rec.pay_byte = b;
                if (!to_end_reg)
                begin
                    if (pay_left_reg == SW'(1))
                    begin
                        hdr_reset = 1'b1;
                    end
                    else
                    begin
                        pay_left_next = pay_left_reg - SW'(1);
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // start of a box payload
        if (begin_pay)
        begin
            hdr_cnt_next = 5'd0;
            if (box_kind_next == jxlcbd_pkg::BOX_JXLP)
            begin
                if (!to_end_next && pay_small)
                begin
                    do_fail   = 1'b1;
                    fail_code = jxlcbd_pkg::ST_SHORT_JXLP;
                end
                else
                begin
                    hdr_cnt_next = 5'd4;
                    found_next   = 1'b1;
                end
            end
            else if (box_kind_next == jxlcbd_pkg::BOX_JXLC)
            begin
                found_next = 1'b1;
            end
            if (!do_fail)
            begin
                if (!to_end_next && pay_zero)
                begin
                    hdr_reset = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAY;
                end
            end
        end

        // next box header
        if (hdr_reset)
        begin
            phase_next    = PH_HDR;
            hdr_cnt_next  = 5'd0;
            box_len_next  = '0;
            box_ovf_next  = 1'b0;
            box_kind_next = '0;
            pay_left_next = '0;
            to_end_next   = 1'b0;
        end

        // first error is kept, rest of the file is dropped
        if (do_fail)
        begin
            if (err_reg == jxlcbd_pkg::ST_OK)
            begin
                err_next = fail_code;
            end
            phase_next = PH_DROP;
        end

        // codestream count, saturating
        if (set_two)
        begin
            cs_count_next = 64'd2;
        end
        else if (inc_one && cs_count_reg != {jxlcbd_pkg::TOTAL_W{1'b1}})
        begin
            cs_count_next = cs_count_reg + 64'd1;
        end

        // closing status item and return to reset
        if (byte_ch.end_of_file)
        begin
            if ((phase_next == PH_SIG || phase_next == PH_FF) &&
                err_next == jxlcbd_pkg::ST_OK)
            begin
                err_next = jxlcbd_pkg::ST_NOT_JXL;
            end
            if (phase_next == PH_PAY && hdr_cnt_next != 5'd0 &&
                err_next == jxlcbd_pkg::ST_OK)
            begin
                err_next = jxlcbd_pkg::ST_SHORT_JXLP;
            end
            if (err_next == jxlcbd_pkg::ST_OK && !found_next)
            begin
                err_next = jxlcbd_pkg::ST_NO_CS;
            end
            rec.st_valid  = 1'b1;
            rec.st_code   = err_next;
            rec.total     = cs_count_next;
            phase_next    = PH_SIG;
            sig_idx_next  = 4'd0;
            hdr_cnt_next  = 5'd0;
            box_len_next  = '0;
            box_ovf_next  = 1'b0;
            box_kind_next = '0;
            pay_left_next = '0;
            to_end_next   = 1'b0;
            found_next    = 1'b0;
            err_next      = jxlcbd_pkg::ST_OK;
            cs_count_next = '0;
        end
    end

    assign push     = accept && (rec.pay_valid || rec.st_valid);
    assign push_rec = rec;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIG;
            sig_idx_reg  <= 4'd0;
            hdr_cnt_reg  <= 5'd0;
            box_len_reg  <= '0;
            box_ovf_reg  <= 1'b0;
            box_kind_reg <= '0;
            pay_left_reg <= '0;
            to_end_reg   <= 1'b0;
            found_reg    <= 1'b0;
            err_reg      <= jxlcbd_pkg::ST_OK;
            cs_count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            sig_idx_reg  <= sig_idx_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            box_len_reg  <= box_len_next;
            box_ovf_reg  <= box_ovf_next;
            box_kind_reg <= box_kind_next;
            pay_left_reg <= pay_left_next;
            to_end_reg   <= to_end_next;
            found_reg    <= found_next;
            err_reg      <= err_next;
            cs_count_reg <= cs_count_next;
        end
    end

    // checks
    `JXLCBD_ASSERT_IMP(a_bare_found, clk, rst_n, phase_reg == PH_BARE, found_reg)
    `JXLCBD_ASSERT_NEXT(a_eof_restart, clk, rst_n, accept && byte_ch.end_of_file,
                        phase_reg == PH_SIG && cs_count_reg == '0)
    `JXLCBD_ASSERT_IMP(a_drop_has_error, clk, rst_n, phase_reg == PH_DROP,
                       err_reg != jxlcbd_pkg::ST_OK)

endmodule

### rtl/core/jxlcbd_queue.sv
// short queue of classified records between front and back
`include "jxl_container_box_deframer_defines.svh"

module jxlcbd_queue #(
    parameter int QUEUE_DEPTH = jxlcbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jxlcbd_pkg::rec_t  push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output jxlcbd_pkg::rec_t  head_rec
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    jxlcbd_pkg::rec_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg;

    assign full       = count_reg == CW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_rec   = mem_reg[rd_ptr_reg];

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // checks
    `JXLCBD_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
    `JXLCBD_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, head_valid)

endmodule

### rtl/core/jxlcbd_back.sv
// back end: expands records into result items, one item per cycle while result_ch is ready
`include "jxl_container_box_deframer_defines.svh"

module jxlcbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  jxlcbd_pkg::rec_t  head_rec,
    output logic              pop,
    jxlcbd_out_if.source      result_ch
);

    // record slot positions in the pending mask
    localparam int SLOT_PAY  = 0;
    localparam int SLOT_PAIR = 1;
    localparam int SLOT_ST   = 2;

    jxlcbd_pkg::rec_t                  cur_rec_reg;
    logic [2:0]                        cur_mask_reg;
    logic                              out_valid_reg;
    logic [jxlcbd_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [jxlcbd_pkg::BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic [jxlcbd_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [jxlcbd_pkg::TOTAL_W-1:0]    out_total_reg, out_total_next;
    logic                              out_last_reg, out_last_next;

    logic                              use_cur;
    jxlcbd_pkg::rec_t                  src_rec;
    logic [2:0]                        src_mask;
    logic [2:0]                        pick;
    logic                              out_free;
    logic                              take;

    // source select: pending record first, else queue head
    always_comb
    begin
        use_cur  = cur_mask_reg != 3'd0;
        src_rec  = use_cur ? cur_rec_reg : head_rec;
        src_mask = 3'd0;
        if (use_cur)
        begin
            src_mask = cur_mask_reg;
        end
        else if (head_valid)
        begin
            src_mask[SLOT_PAY]  = head_rec.pay_valid;
            src_mask[SLOT_PAIR] = head_rec.pair;
            src_mask[SLOT_ST]   = head_rec.st_valid;
        end
        out_free = !out_valid_reg || result_ch.ready;
        take     = out_free && (src_mask != 3'd0);
        pick     = src_mask & (~src_mask + 3'd1);
    end

    assign pop = take && !use_cur;

    // next result item
    always_comb
    begin
        out_kind_next   = jxlcbd_pkg::KIND_STATUS;
        out_byte_next   = '0;
        out_status_next = src_rec.st_code;
        out_total_next  = src_rec.total;
        out_last_next   = 1'b1;
        if (pick[SLOT_PAY])
        begin
            out_kind_next   = src_rec.pay_kind;
            out_byte_next   = src_rec.pay_byte;
            out_status_next = jxlcbd_pkg::ST_OK;
            out_total_next  = '0;
            out_last_next   = 1'b0;
        end
        else if (pick[SLOT_PAIR])
        begin
            out_kind_next   = jxlcbd_pkg::KIND_CS;
            out_byte_next   = jxlcbd_pkg::BARE_MARK1;
            out_status_next = jxlcbd_pkg::ST_OK;
            out_total_next  = '0;
            out_last_next   = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_mask_reg  <= 3'd0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= take;
            end
            if (take)
            begin
                cur_mask_reg <= src_mask & ~pick;
            end
        end
    end

    // output and pending record payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_total_reg  <= out_total_next;
            out_last_reg   <= out_last_next;
        end
        if (pop)
        begin
            cur_rec_reg <= head_rec;
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.kind             = out_kind_reg;
    assign result_ch.byte_out         = out_byte_reg;
    assign result_ch.status           = out_status_reg;
    assign result_ch.codestream_total = out_total_reg;
    assign result_ch.last_of_file     = out_last_reg;

    // checks
    `JXLCBD_ASSERT_IMP(a_status_is_last, clk, rst_n,
                       out_valid_reg && out_kind_reg == jxlcbd_pkg::KIND_STATUS, out_last_reg)
    `JXLCBD_ASSERT_IMP(a_pending_blocks_pop, clk, rst_n, cur_mask_reg != 3'd0, !pop)

endmodule
